FILE: hdl/swbc_pkg.sv
// shared types, constants and helpers of the swept box collision resolver
package swbc_pkg;

  // table and fixed point shape
  localparam int TABLE_DEPTH = 64;
  localparam int PASS_LIMIT  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 7;
  localparam int PASS_W      = $clog2(PASS_LIMIT + 2);
  localparam int DCNT_W      = $clog2(FRAC_BITS);

  // geometry word, wide enough for sums of positions and sizes
  localparam int G_W  = 40;
  // time operand of the multiplier: 0 .. one plus a sign bit
  localparam int MB_W = FRAC_BITS + 2;

  typedef logic signed [G_W-1:0]  geo_t;
  typedef logic [MB_W-1:0]        time_t;
  typedef logic signed [MB_W-1:0] mulb_t;
  typedef logic signed [G_W+MB_W-1:0] prod_t;

  localparam time_t Q_ONE = time_t'(1) << FRAC_BITS;
  localparam geo_t  EPS   = geo_t'(1);

  // configuration register indexes
  localparam logic [1:0] CFG_PLATFORM_COUNT = 2'd0;
  localparam logic [1:0] CFG_PLAYER_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_PLAYER_HEIGHT  = 2'd2;

  // request types
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_RESOLVE = 1'b1;

  // contact side bits
  localparam logic [3:0] SIDE_TOP    = 4'b0001;
  localparam logic [3:0] SIDE_BOTTOM = 4'b0010;
  localparam logic [3:0] SIDE_LEFT   = 4'b0100;
  localparam logic [3:0] SIDE_RIGHT  = 4'b1000;

  // one stored platform
  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] bottom;
    logic [30:0]        width;
    logic [30:0]        height;
    logic               jumpthrough;
  } entry_t;

  // sign extend a 32-bit position
  function automatic geo_t ext_s32(input logic signed [31:0] v);
    ext_s32 = geo_t'(v);
  endfunction

  // zero extend a 31-bit size
  function automatic geo_t ext_u31(input logic [30:0] v);
    ext_u31 = geo_t'({1'b0, v});
  endfunction

  // clamp to the 32-bit signed range
  function automatic geo_t sat32(input geo_t v);
    geo_t hi;
    geo_t lo;
    hi = geo_t'(32'sh7fff_ffff);
    lo = -hi - geo_t'(1);
    if (v > hi) sat32 = hi;
    else if (v < lo) sat32 = lo;
    else sat32 = v;
  endfunction

endpackage

FILE: hdl/swept_box_collision_resolver.sv
// swept box collision resolver: platform table, sequencer, shared divider and multiplier
//
//   channel | direction | handshake            | payload
//   in_     | request   | in_valid / in_ready   | req_type, entry, boxes, last pos, velocity
//   out_    | result    | out_valid / out_ready | resolved pos, last pos, velocity, contact
//   cfg_    | write     | cfg_we                | cfg_index, cfg_wdata
//
// a load request writes the table and goes straight to the done state. a resolve request runs passes of box tests;
// the length of a box test depends on the 16-step restoring divider and the
// single multiplier shared by both axes, and each pass ends with an update sequence.
// up to PASS_LIMIT+1 passes over platform_count boxes.
// reset is synchronous and clears the sequencer and flags; the table is not cleared.
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register while the next request is taken, and a result stalls the sequencer
// only when the previous one has not yet been taken.
module swept_box_collision_resolver import swbc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_wdata,
  // requests
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_box_x,
  input  logic signed [31:0] in_box_y,
  input  logic [30:0]        in_box_width,
  input  logic [30:0]        in_box_height,
  input  logic               in_box_jumpthrough,
  input  logic signed [31:0] in_last_x,
  input  logic signed [31:0] in_last_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_x,
  output logic signed [31:0] out_new_y,
  output logic signed [31:0] out_new_last_x,
  output logic signed [31:0] out_new_last_y,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic [3:0]         out_contact_sides,
  output logic [5:0]         out_contact_index,
  output logic               out_any_contact,
  output logic               out_limit_reached
);

  // sequencer states
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_PASS  = 5'd1;
  localparam logic [4:0] ST_RD    = 5'd2;
  localparam logic [4:0] ST_GEO   = 5'd3;
  localparam logic [4:0] ST_XCHK  = 5'd4;
  localparam logic [4:0] ST_DPREP = 5'd5;
  localparam logic [4:0] ST_DIV   = 5'd6;
  localparam logic [4:0] ST_XMUL  = 5'd7;
  localparam logic [4:0] ST_MUL   = 5'd8;
  localparam logic [4:0] ST_XPOS  = 5'd9;
  localparam logic [4:0] ST_YCHK  = 5'd10;
  localparam logic [4:0] ST_YMUL  = 5'd11;
  localparam logic [4:0] ST_YPOS  = 5'd12;
  localparam logic [4:0] ST_EVAL  = 5'd13;
  localparam logic [4:0] ST_CMP   = 5'd14;
  localparam logic [4:0] ST_NEXT  = 5'd15;
  localparam logic [4:0] ST_PEND  = 5'd16;
  localparam logic [4:0] ST_U1    = 5'd17;
  localparam logic [4:0] ST_U2    = 5'd18;
  localparam logic [4:0] ST_U3    = 5'd19;
  localparam logic [4:0] ST_U4    = 5'd20;
  localparam logic [4:0] ST_U5    = 5'd21;
  localparam logic [4:0] ST_U6    = 5'd22;
  localparam logic [4:0] ST_U7    = 5'd23;
  localparam logic [4:0] ST_DONE  = 5'd24;

  // configuration registers
  logic [CNT_W-1:0] platform_count_r;
  logic [30:0]      player_width_r;
  logic [30:0]      player_height_r;

  // control
  logic [4:0]       state_r;
  logic [4:0]       div_ret_r;
  logic [4:0]       mul_ret_r;
  logic             load_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] k_r;
  logic [PASS_W-1:0] passes_r;
  logic             hit_r;
  logic             hx_r;
  logic             hy_r;
  logic             any_r;
  logic             limit_r;
  logic             out_valid_r;

  // moving box
  geo_t  px_r, py_r, lx_r, ly_r, vx_r, vy_r;
  geo_t  mr_r, mt_r, lr_r, lt_r;
  time_t rem_r;

  // platform under test
  entry_t mem [TABLE_DEPTH];
  entry_t ent_q_r;
  geo_t   sl_r, sb_r, sr_r, st_r;
  logic   jt_r;

  // per-test results
  logic [3:0] sides_r;
  time_t      tx_r, ty_r;
  geo_t       nx_r, ny_r;
  time_t      cur_time_r;
  geo_t       cur_area_r;
  logic       cur_axis_y_r;

  // best hit of the pass
  time_t      best_time_r;
  geo_t       best_area_r;
  logic       best_axis_y_r;
  logic [3:0] best_sides_r;
  logic [IDX_W-1:0] best_idx_r;

  // last chosen contact
  logic [3:0]       csides_r;
  logic [IDX_W-1:0] cidx_r;

  // divider
  geo_t              dnum_r, dden_r;
  logic [G_W-1:0]    drem_r, aden_r;
  time_t             dq_r;
  logic [DCNT_W-1:0] dcnt_r;

  // multiplier
  geo_t  mul_a_r;
  mulb_t mul_b_r;
  prod_t prod_r;
  geo_t  sh;

  // output register
  logic signed [31:0] o_x_r, o_y_r, o_lx_r, o_ly_r, o_vx_r, o_vy_r;
  logic [3:0]         o_sides_r;
  logic [5:0]         o_idx_r;
  logic               o_any_r, o_limit_r;

  // combinational helpers
  geo_t  pw, ph;
  logic  ovl_y, ovl_x, x_right, x_left, y_bot, y_top;
  geo_t  anum, aden;
  logic  dsign_diff;
  logic [G_W:0] dtrial;
  geo_t  nyc, nxc;
  geo_t  area_y, area_x;
  time_t one_minus_t;
  logic  axis_y;
  logic  accept;

  assign pw = ext_u31(player_width_r);
  assign ph = ext_u31(player_height_r);
  assign sh = geo_t'(prod_r >>> FRAC_BITS);
  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign one_minus_t = Q_ONE - best_time_r;

  // overlap and approach tests of both axes
  always_comb begin
    ovl_y   = ((py_r < ly_r) ? py_r : ly_r) < st_r - EPS &&
              ((mt_r > lt_r) ? mt_r : lt_r) > sb_r + EPS;
    x_right = lr_r <= sl_r + EPS && mr_r > sl_r + EPS;
    x_left  = lx_r >= sr_r - EPS && px_r < sr_r - EPS;
    ovl_x   = ((px_r < lx_r) ? px_r : lx_r) < sr_r - EPS &&
              ((mr_r > lr_r) ? mr_r : lr_r) > sl_r + EPS;
    y_bot   = lt_r <= sb_r + EPS && mt_r > sb_r + EPS;
    y_top   = ly_r >= st_r - EPS && py_r < st_r - EPS;
  end

  // divider operand magnitudes and trial subtract
  always_comb begin
    anum = dnum_r[G_W-1] ? -dnum_r : dnum_r;
    aden = dden_r[G_W-1] ? -dden_r : dden_r;
    dsign_diff = dnum_r[G_W-1] ^ dden_r[G_W-1];
    dtrial = {drem_r, 1'b0};
  end

  // contact points and overlap lengths
  always_comb begin
    nyc = ly_r + sh;
    nxc = lx_r + sh;
    area_y = (((sr_r < nx_r + pw) ? sr_r : nx_r + pw) - ((sl_r > nx_r) ? sl_r : nx_r));
    area_x = (((st_r < ny_r + ph) ? st_r : ny_r + ph) - ((sb_r > ny_r) ? sb_r : ny_r));
    axis_y = !hx_r || (hy_r && ty_r < tx_r);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      platform_count_r <= '0;
      player_width_r   <= '0;
      player_height_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PLATFORM_COUNT: platform_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_PLAYER_WIDTH:   player_width_r   <= cfg_wdata;
        CFG_PLAYER_HEIGHT:  player_height_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // platform table
  always_ff @(posedge clk) begin
    if (accept && in_req_type == REQ_LOAD) begin
      mem[in_entry_index[IDX_W-1:0]] <= '{left: in_box_x, bottom: in_box_y,
                                          width: in_box_width, height: in_box_height,
                                          jumpthrough: in_box_jumpthrough};
    end
    ent_q_r <= mem[k_r[IDX_W-1:0]];
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod_r <= mul_a_r * mul_b_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      div_ret_r   <= ST_IDLE;
      mul_ret_r   <= ST_IDLE;
      k_r         <= '0;
      passes_r    <= '0;
      hit_r       <= 1'b0;
      hx_r        <= 1'b0;
      hy_r        <= 1'b0;
      any_r       <= 1'b0;
      limit_r     <= 1'b0;
      load_r      <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            load_r   <= (in_req_type == REQ_LOAD);
            px_r     <= ext_s32(in_box_x);
            py_r     <= ext_s32(in_box_y);
            lx_r     <= ext_s32(in_last_x);
            ly_r     <= ext_s32(in_last_y);
            vx_r     <= ext_s32(in_vel_x);
            vy_r     <= ext_s32(in_vel_y);
            count_r  <= (platform_count_r > CNT_W'(TABLE_DEPTH)) ?
                        CNT_W'(TABLE_DEPTH) : platform_count_r;
            rem_r    <= Q_ONE;
            passes_r <= '0;
            any_r    <= 1'b0;
            limit_r  <= 1'b0;
            csides_r <= '0;
            cidx_r   <= '0;
            state_r  <= (in_req_type == REQ_LOAD) ? ST_DONE : ST_PASS;
          end
        end
        ST_PASS: begin
          // start of a pass: fix the swept box bounds
          mr_r        <= px_r + pw;
          mt_r        <= py_r + ph;
          lr_r        <= lx_r + pw;
          lt_r        <= ly_r + ph;
          k_r         <= '0;
          hit_r       <= 1'b0;
          best_time_r <= Q_ONE + time_t'(1);
          best_area_r <= '0;
          state_r     <= (count_r == '0) ? ST_DONE : ST_RD;
        end
        ST_RD: begin
          state_r <= ST_GEO;
        end
        ST_GEO: begin
          sl_r    <= ext_s32(ent_q_r.left);
          sb_r    <= ext_s32(ent_q_r.bottom);
          sr_r    <= ext_s32(ent_q_r.left) + ext_u31(ent_q_r.width);
          st_r    <= ext_s32(ent_q_r.bottom) + ext_u31(ent_q_r.height);
          jt_r    <= ent_q_r.jumpthrough;
          hx_r    <= 1'b0;
          hy_r    <= 1'b0;
          sides_r <= '0;
          state_r <= ST_XCHK;
        end
        ST_XCHK: begin
          // horizontal approach
          dden_r    <= px_r - lx_r;
          div_ret_r <= ST_XMUL;
          if (ovl_y && x_right) begin
            hx_r    <= 1'b1;
            sides_r <= sides_r | SIDE_RIGHT;
            dnum_r  <= sl_r - lr_r;
            state_r <= ST_DPREP;
          end else if (ovl_y && x_left) begin
            hx_r    <= 1'b1;
            sides_r <= sides_r | SIDE_LEFT;
            dnum_r  <= sr_r - lx_r;
            state_r <= ST_DPREP;
          end else begin
            state_r <= ST_YCHK;
          end
        end
        ST_DPREP: begin
          // trivial quotients, else start long division
          dq_r   <= '0;
          dcnt_r <= '0;
          if (dden_r == '0 || dnum_r == '0 || dsign_diff) begin
            state_r <= div_ret_r;
          end else if (anum >= aden) begin
            dq_r    <= Q_ONE;
            state_r <= div_ret_r;
          end else begin
            drem_r  <= anum;
            aden_r  <= aden;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle
          if (dtrial >= {1'b0, aden_r}) begin
            drem_r <= G_W'(dtrial - {1'b0, aden_r});
            dq_r   <= {dq_r[MB_W-2:0], 1'b1};
          end else begin
            drem_r <= dtrial[G_W-1:0];
            dq_r   <= {dq_r[MB_W-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(FRAC_BITS - 1)) state_r <= div_ret_r;
        end
        ST_XMUL: begin
          tx_r      <= dq_r;
          mul_a_r   <= py_r - ly_r;
          mul_b_r   <= mulb_t'(dq_r);
          mul_ret_r <= ST_XPOS;
          state_r   <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= mul_ret_r;
        end
        ST_XPOS: begin
          ny_r <= nyc;
          if (nyc >= st_r - EPS || nyc + ph <= sb_r + EPS) begin
            hx_r    <= 1'b0;
            sides_r <= sides_r & ~(SIDE_LEFT | SIDE_RIGHT);
          end
          state_r <= ST_YCHK;
        end
        ST_YCHK: begin
          // vertical approach, top skipped on jump-through boxes
          dden_r    <= py_r - ly_r;
          div_ret_r <= ST_YMUL;
          if (ovl_x && y_bot) begin
            hy_r    <= 1'b1;
            sides_r <= sides_r | SIDE_BOTTOM;
            dnum_r  <= sb_r - lt_r;
            state_r <= ST_DPREP;
          end else if (ovl_x && y_top && !jt_r) begin
            hy_r    <= 1'b1;
            sides_r <= sides_r | SIDE_TOP;
            dnum_r  <= st_r - ly_r;
            state_r <= ST_DPREP;
          end else begin
            state_r <= ST_EVAL;
          end
        end
        ST_YMUL: begin
          ty_r      <= dq_r;
          mul_a_r   <= px_r - lx_r;
          mul_b_r   <= mulb_t'(dq_r);
          mul_ret_r <= ST_YPOS;
          state_r   <= ST_MUL;
        end
        ST_YPOS: begin
          nx_r <= nxc;
          if (nxc >= sr_r - EPS || nxc + pw <= sl_r + EPS) begin
            hy_r    <= 1'b0;
            sides_r <= sides_r & ~(SIDE_TOP | SIDE_BOTTOM);
          end
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          cur_axis_y_r <= axis_y;
          cur_time_r   <= axis_y ? ty_r : tx_r;
          cur_area_r   <= axis_y ? area_y : area_x;
          state_r      <= (!hx_r && !hy_r) ? ST_NEXT : ST_CMP;
        end
        ST_CMP: begin
          // earliest hit, near ties go to the larger overlap
          if (cur_time_r < best_time_r ||
              (cur_time_r < best_time_r + time_t'(1) && cur_area_r > best_area_r)) begin
            best_time_r   <= cur_time_r;
            best_area_r   <= cur_area_r;
            best_axis_y_r <= cur_axis_y_r;
            best_sides_r  <= sides_r;
            best_idx_r    <= k_r[IDX_W-1:0];
            hit_r         <= 1'b1;
          end
          state_r <= ST_NEXT;
        end
        ST_NEXT: begin
          if (k_r + CNT_W'(1) == count_r) begin
            state_r <= ST_PEND;
          end else begin
            k_r     <= k_r + CNT_W'(1);
            state_r <= ST_RD;
          end
        end
        ST_PEND: begin
          if (!hit_r) begin
            state_r <= ST_DONE;
          end else begin
            any_r     <= 1'b1;
            csides_r  <= best_sides_r;
            cidx_r    <= best_idx_r;
            mul_a_r   <= px_r - lx_r;
            mul_b_r   <= mulb_t'(best_time_r);
            mul_ret_r <= ST_U1;
            state_r   <= ST_MUL;
          end
        end
        ST_U1: begin
          // move to the contact point
          px_r      <= sat32(lx_r + sh);
          mul_a_r   <= py_r - ly_r;
          mul_b_r   <= mulb_t'(best_time_r);
          mul_ret_r <= ST_U2;
          state_r   <= ST_MUL;
        end
        ST_U2: begin
          py_r      <= sat32(ly_r + sh);
          ly_r      <= sat32(ly_r + sh);
          lx_r      <= px_r;
          if (best_axis_y_r) vy_r <= '0;
          else vx_r <= '0;
          mul_a_r   <= best_axis_y_r ? vx_r : '0;
          mul_b_r   <= mulb_t'(one_minus_t);
          mul_ret_r <= ST_U3;
          state_r   <= ST_MUL;
        end
        ST_U3: begin
          // re-project over the remaining slice
          mul_a_r   <= sh;
          mul_b_r   <= mulb_t'(rem_r);
          mul_ret_r <= ST_U4;
          state_r   <= ST_MUL;
        end
        ST_U4: begin
          px_r      <= sat32(px_r + sh);
          mul_a_r   <= vy_r;
          mul_b_r   <= mulb_t'(one_minus_t);
          mul_ret_r <= ST_U5;
          state_r   <= ST_MUL;
        end
        ST_U5: begin
          mul_a_r   <= sh;
          mul_b_r   <= mulb_t'(rem_r);
          mul_ret_r <= ST_U6;
          state_r   <= ST_MUL;
        end
        ST_U6: begin
          py_r      <= sat32(py_r + sh);
          mul_a_r   <= geo_t'({1'b0, one_minus_t});
          mul_b_r   <= mulb_t'(rem_r);
          mul_ret_r <= ST_U7;
          state_r   <= ST_MUL;
        end
        ST_U7: begin
          rem_r    <= time_t'(sh);
          passes_r <= passes_r + PASS_W'(1);
          if (passes_r + PASS_W'(1) > PASS_W'(PASS_LIMIT)) begin
            limit_r <= 1'b1;
            state_r <= ST_DONE;
          end else if (sh > EPS) begin
            state_r <= ST_PASS;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result register, loaded as the sequencer leaves its last state
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      o_x_r     <= load_r ? '0 : px_r[31:0];
      o_y_r     <= load_r ? '0 : py_r[31:0];
      o_lx_r    <= load_r ? '0 : lx_r[31:0];
      o_ly_r    <= load_r ? '0 : ly_r[31:0];
      o_vx_r    <= load_r ? '0 : vx_r[31:0];
      o_vy_r    <= load_r ? '0 : vy_r[31:0];
      o_sides_r <= csides_r;
      o_idx_r   <= 6'(cidx_r);
      o_any_r   <= any_r;
      o_limit_r <= limit_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_x         = o_x_r;
  assign out_new_y         = o_y_r;
  assign out_new_last_x    = o_lx_r;
  assign out_new_last_y    = o_ly_r;
  assign out_new_vel_x     = o_vx_r;
  assign out_new_vel_y     = o_vy_r;
  assign out_contact_sides = o_sides_r;
  assign out_contact_index = o_idx_r;
  assign out_any_contact   = o_any_r;
  assign out_limit_reached = o_limit_r;

endmodule

FILE: hdl/swbc_checker.sv
// port checker of the swept box collision resolver and its bind
module swbc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_new_x,
  input logic [3:0]         out_contact_sides,
  input logic [5:0]         out_contact_index,
  input logic               out_any_contact,
  input logic               out_limit_reached
);

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_new_x) && $stable(out_contact_sides))
    else $error("stalled result changed");

  // a taken request busies the block
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after request taken");

  // no contact means no contact details
  a_no_contact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_contact |-> out_contact_sides == 4'd0 &&
                                      out_contact_index == 6'd0)
    else $error("contact details without contact");

  // the pass limit only trips after contacts
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_limit_reached |-> out_any_contact)
    else $error("limit without contact");

endmodule

bind swept_box_collision_resolver swbc_checker u_swbc_checker (.*);

FILE: verif/tb_top.sv
// regression testbench for the swept box collision resolver
module tb_top import swbc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QONE = 64'sd65536;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [30:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               in_req_type;
  logic [5:0]         in_entry_index;
  logic signed [31:0] in_box_x;
  logic signed [31:0] in_box_y;
  logic [30:0]        in_box_width;
  logic [30:0]        in_box_height;
  logic               in_box_jumpthrough;
  logic signed [31:0] in_last_x;
  logic signed [31:0] in_last_y;
  logic signed [31:0] in_vel_x;
  logic signed [31:0] in_vel_y;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_new_x;
  logic signed [31:0] out_new_y;
  logic signed [31:0] out_new_last_x;
  logic signed [31:0] out_new_last_y;
  logic signed [31:0] out_new_vel_x;
  logic signed [31:0] out_new_vel_y;
  logic [3:0]         out_contact_sides;
  logic [5:0]         out_contact_index;
  logic               out_any_contact;
  logic               out_limit_reached;

  // one resolved motion
  typedef struct {
    logic signed [31:0] x, y, lx, ly, vx, vy;
    logic [3:0]         sides;
    logic [5:0]         idx;
    logic               any_c, lim;
  } motion_t;

  motion_t motion_q[$];

  // predictor copy of the table and registers
  longint plat_left[TABLE_DEPTH];
  longint plat_bottom[TABLE_DEPTH];
  longint plat_w[TABLE_DEPTH];
  longint plat_h[TABLE_DEPTH];
  bit     plat_jt[TABLE_DEPTH];
  int     count_reg;
  longint pw_reg, ph_reg;

  int errors;
  int mismatches;
  bit hold_off;
  bit rx_pattern;

  swept_box_collision_resolver dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #400ms;
    $display("swept_box_collision_resolver regression: fail");
    $finish;
  end

  function automatic longint mn(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint mx(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // q product, floored: for a negative product the magnitude is rounded up
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) return p >>> FRAC_BITS;
    return -((-p + QONE - 1) >>> FRAC_BITS);
  endfunction

  function automatic longint qdiv(longint num, longint den);
    longint q;
    if (den == 0) return 0;
    q = (num * QONE) / den;
    if (q < 0) return 0;
    if (q > QONE) return QONE;
    return q;
  endfunction

  // swept test of the moving box against one platform
  function automatic bit box_sweep(int k, longint px, longint py, longint lx, longint ly,
                                   output longint t, output longint area,
                                   output bit on_y, output logic [3:0] sd);
    longint sl, sb, sr, st, tx, ty, nx, ny;
    bit hx, hy;
    sl = plat_left[k]; sb = plat_bottom[k];
    sr = sl + plat_w[k]; st = sb + plat_h[k];
    tx = 0; ty = 0; nx = 0; ny = 0; hx = 0; hy = 0; sd = 4'b0;
    t = 0; area = 0; on_y = 0;
    if (mn(py, ly) < st - 1 && mx(py + ph_reg, ly + ph_reg) > sb + 1) begin
      if (lx + pw_reg <= sl + 1 && px + pw_reg > sl + 1) begin
        hx = 1; sd |= SIDE_RIGHT; tx = qdiv(sl - (lx + pw_reg), px - lx);
      end else if (lx >= sr - 1 && px < sr - 1) begin
        hx = 1; sd |= SIDE_LEFT; tx = qdiv(sr - lx, px - lx);
      end
      if (hx) begin
        ny = ly + qmul(py - ly, tx);
        if (ny >= st - 1 || ny + ph_reg <= sb + 1) begin
          hx = 0; sd &= ~(SIDE_LEFT | SIDE_RIGHT);
        end
      end
    end
    if (mn(px, lx) < sr - 1 && mx(px + pw_reg, lx + pw_reg) > sl + 1) begin
      if (ly + ph_reg <= sb + 1 && py + ph_reg > sb + 1) begin
        hy = 1; sd |= SIDE_BOTTOM; ty = qdiv(sb - (ly + ph_reg), py - ly);
      end else if (ly >= st - 1 && py < st - 1) begin
        if (!plat_jt[k]) begin
          hy = 1; sd |= SIDE_TOP; ty = qdiv(st - ly, py - ly);
        end
      end
      if (hy) begin
        nx = lx + qmul(px - lx, ty);
        if (nx >= sr - 1 || nx + pw_reg <= sl + 1) begin
          hy = 0; sd &= ~(SIDE_TOP | SIDE_BOTTOM);
        end
      end
    end
    if (!hx && !hy) return 0;
    if (!hx || (hy && ty < tx)) begin
      t = ty; on_y = 1; area = mn(sr, nx + pw_reg) - mx(sl, nx);
    end else begin
      t = tx; on_y = 0; area = mn(st, ny + ph_reg) - mx(sb, ny);
    end
    return 1;
  endfunction

  // predicted outcome of one request
  function automatic motion_t resolve_motion(bit rt, int e, longint bx, longint by,
      longint bw, longint bh, bit bj, longint lx, longint ly, longint vx, longint vy);
    motion_t m;
    longint px, py, rem, bt, barea, t, area;
    bit bon_y, on_y, hit;
    logic [3:0] bsd, sd;
    int cnt, bidx, passes;
    m = '{default: '0};
    if (rt == REQ_LOAD) begin
      plat_left[e] = bx; plat_bottom[e] = by; plat_w[e] = bw; plat_h[e] = bh;
      plat_jt[e] = bj;
      return m;
    end
    px = bx; py = by;
    cnt = count_reg > TABLE_DEPTH ? TABLE_DEPTH : count_reg;
    rem = QONE; passes = 0;
    while (rem > 1) begin
      hit = 0; bidx = 0; bt = QONE + 1; barea = 0; bon_y = 0; bsd = 0;
      for (int k = 0; k < cnt; k++) begin
        if (box_sweep(k, px, py, lx, ly, t, area, on_y, sd)) begin
          if (t < bt || (t < bt + 1 && area > barea)) begin
            bt = t; barea = area; bon_y = on_y; bsd = sd; bidx = k; hit = 1;
          end
        end
      end
      if (!hit) break;
      m.any_c = 1; m.sides = bsd; m.idx = bidx[5:0];
      px = clamp32(lx + qmul(px - lx, bt));
      py = clamp32(ly + qmul(py - ly, bt));
      if (bon_y) vy = 0; else vx = 0;
      lx = px; ly = py;
      px = clamp32(px + qmul(qmul(vx, QONE - bt), rem));
      py = clamp32(py + qmul(qmul(vy, QONE - bt), rem));
      rem = qmul(QONE - bt, rem);
      passes++;
      if (passes > PASS_LIMIT) begin
        m.lim = 1;
        break;
      end
    end
    m.x = px[31:0]; m.y = py[31:0]; m.lx = lx[31:0]; m.ly = ly[31:0];
    m.vx = vx[31:0]; m.vy = vy[31:0];
    return m;
  endfunction

  // receiver stall pattern, overridden by the long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else if (rx_pattern) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    motion_t m;
    if (rst_n && out_valid && out_ready) begin
      if (motion_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        m = motion_q.pop_front();
        if (out_new_x !== m.x || out_new_y !== m.y || out_new_last_x !== m.lx ||
            out_new_last_y !== m.ly || out_new_vel_x !== m.vx || out_new_vel_y !== m.vy ||
            out_contact_sides !== m.sides || out_contact_index !== m.idx ||
            out_any_contact !== m.any_c || out_limit_reached !== m.lim) begin
          errors++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp x=%h y=%h lx=%h ly=%h vx=%h vy=%h s=%h i=%0d a=%b l=%b",
                     m.x, m.y, m.lx, m.ly, m.vx, m.vy, m.sides, m.idx, m.any_c, m.lim);
            $display("         got x=%h y=%h lx=%h ly=%h vx=%h vy=%h s=%h i=%0d a=%b l=%b",
                     out_new_x, out_new_y, out_new_last_x, out_new_last_y, out_new_vel_x,
                     out_new_vel_y, out_contact_sides, out_contact_index, out_any_contact,
                     out_limit_reached);
          end
        end
      end
    end
  end

  // drop valid while the sender idles
  task automatic idle_input;
    in_valid <= 1'b0;
  endtask

  // send one request, predicting it at acceptance; valid stays up until the
  // next request replaces it or the sender idles
  task automatic send_request(bit rt, int e, longint bx, longint by, longint bw,
      longint bh, bit bj, longint lx, longint ly, longint vx, longint vy);
    in_req_type <= rt; in_entry_index <= e[5:0];
    in_box_x <= bx[31:0]; in_box_y <= by[31:0];
    in_box_width <= bw[30:0]; in_box_height <= bh[30:0]; in_box_jumpthrough <= bj;
    in_last_x <= lx[31:0]; in_last_y <= ly[31:0];
    in_vel_x <= vx[31:0]; in_vel_y <= vy[31:0];
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    motion_q.push_back(resolve_motion(rt, e, bx, by, bw, bh, bj, lx, ly, vx, vy));
    @(negedge clk);
  endtask

  task automatic load_platform(int e, longint l, longint b, longint w, longint h, bit j);
    send_request(REQ_LOAD, e, l, b, w, h, j, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic resolve(longint x, longint y, longint lx, longint ly,
                         longint vx, longint vy);
    send_request(REQ_RESOLVE, $urandom_range(0, 63), x, y, $urandom_range(0, 32'h7fffffff),
                 $urandom_range(0, 32'h7fffffff), $urandom_range(0, 1), lx, ly, vx, vy);
  endtask

  // idle wait then register write
  task automatic write_reg(logic [1:0] idx, longint val);
    idle_input();
    while (motion_q.size() != 0) @(negedge clk);
    repeat (4000) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val[30:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PLATFORM_COUNT: count_reg = int'(val & 64'h7f);
      CFG_PLAYER_WIDTH:   pw_reg = val & 31'h7fffffff;
      default:            ph_reg = val & 31'h7fffffff;
    endcase
  endtask

  // directed: field extremes, loads, contact from each side, jump-through
  task automatic test_directed;
    write_reg(CFG_PLAYER_WIDTH, 32'h0001_0000);
    write_reg(CFG_PLAYER_HEIGHT, 32'h0002_0000);
    write_reg(CFG_PLATFORM_COUNT, 0);
    resolve(32'sh7fffffff, -64'sh80000000, -64'sh80000000, 32'sh7fffffff,
            -64'sh80000000, 32'sh7fffffff);
    load_platform(0, 0, 0, 32'h000a_0000, 32'h0001_0000, 0);
    load_platform(1, 32'h0005_0000, 32'h0003_0000, 32'h0001_0000, 32'h000a_0000, 0);
    load_platform(2, -32'sh0005_0000, 32'h0008_0000, 32'h0004_0000, 32'h0001_0000, 1);
    load_platform(63, 32'h7fff0000, -64'sh80000000, 31'h7fffffff, 31'h7fffffff, 1);
    load_platform(3, -64'sh80000000, 32'h7fff0000, 0, 0, 0);
    write_reg(CFG_PLATFORM_COUNT, 4);
    resolve(32'h0002_0000, 32'h0000_8000, 32'h0002_0000, 32'h0003_0000, 0, -32'sh2_0000);
    resolve(32'h0006_0000, 32'h0004_0000, 32'h0002_0000, 32'h0004_0000, 32'h4_0000, 0);
    resolve(32'h0007_0000, 32'h0004_0000, 32'h0009_0000, 32'h0004_0000, -32'sh2_0000, 0);
    resolve(32'h0002_0000, -32'sh0001_0000, 32'h0002_0000, -32'sh0004_0000, 0, 32'h3_0000);
    resolve(-32'sh0003_0000, 32'h0008_8000, -32'sh0003_0000, 32'h000a_0000, 0, -32'sh1_0000);
    resolve(-32'sh0003_0000, 32'h0007_0000, -32'sh0003_0000, 32'h0005_0000, 0, 32'sh1_0000);
    resolve(32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 0, 0);
  endtask

  // a pit with walls: velocity drives many re-projections; count above depth is clamped
  task automatic test_pass_limit;
    for (int k = 0; k < 64; k++)
      load_platform(k, (k % 2) ? 32'h0004_0000 : -32'sh0004_0000, -32'sh0010_0000,
                    32'h0001_0000, 32'h0020_0000, 0);
    write_reg(CFG_PLAYER_WIDTH, 32'h0003_0000);
    write_reg(CFG_PLAYER_HEIGHT, 32'h0001_0000);
    write_reg(CFG_PLATFORM_COUNT, 127);
    resolve(32'h0002_0000, 0, -32'sh0001_0000, 0, 32'h7fff_0000, 32'h1_0000);
    resolve(-32'sh0003_0000, 32'h0001_0000, -32'sh0001_0000, 0, -64'sh8000_0000, 32'h1);
  endtask

  // random loads and resolves near the loaded platforms
  task automatic test_random(int n);
    int e;
    longint cx, cy;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        e = $urandom_range(0, 63);
        if ($urandom_range(0, 9) == 0)
          load_platform(e, $signed($urandom), $signed($urandom), $urandom_range(0, 32'h7fffffff),
                        $urandom_range(0, 32'h7fffffff), $urandom_range(0, 1));
        else
          load_platform(e, $signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000,
                        $signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000,
                        $urandom_range(0, 32'h10_0000), $urandom_range(0, 32'h10_0000),
                        $urandom_range(0, 1));
      end else if ($urandom_range(0, 9) == 0) begin
        resolve($signed($urandom), $signed($urandom), $signed($urandom), $signed($urandom),
                $signed($urandom), $signed($urandom));
      end else begin
        cx = $signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000;
        cy = $signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000;
        resolve(cx + $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000,
                cy + $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000, cx, cy,
                $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000,
                $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
      end
      // bursts with gaps
      if ($urandom_range(0, 3) == 0) begin
        idle_input();
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
      if (i == n / 2) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (20000) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
    end
  endtask

  initial begin
    errors = 0; mismatches = 0; hold_off = 0; rx_pattern = 0;
    count_reg = 0; pw_reg = 0; ph_reg = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = CFG_PLATFORM_COUNT; cfg_wdata = '0;
    in_valid = 1'b0; in_req_type = REQ_LOAD; in_entry_index = '0;
    in_box_x = '0; in_box_y = '0; in_box_width = '0; in_box_height = '0;
    in_box_jumpthrough = 1'b0; in_last_x = '0; in_last_y = '0; in_vel_x = '0; in_vel_y = '0;
    out_ready = 1'b0;
    // platforms start all zero-sized at origin until each slot is loaded
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      plat_left[k] = 0; plat_bottom[k] = 0; plat_w[k] = 0; plat_h[k] = 0; plat_jt[k] = 0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    rx_pattern = 1;
    test_pass_limit();
    write_reg(CFG_PLAYER_WIDTH, 31'h7fffffff);
    write_reg(CFG_PLAYER_HEIGHT, 31'h7fffffff);
    test_random(20);
    write_reg(CFG_PLAYER_WIDTH, $urandom_range(0, 32'h4_0000));
    write_reg(CFG_PLAYER_HEIGHT, $urandom_range(0, 32'h4_0000));
    write_reg(CFG_PLATFORM_COUNT, $urandom_range(1, 64));
    test_random(40);
    idle_input();
    while (motion_q.size() != 0) @(negedge clk);
    repeat (4000) @(negedge clk);
    if (errors == 0) $display("swept_box_collision_resolver regression: pass");
    else $display("swept_box_collision_resolver regression: fail");
    $finish;
  end

endmodule

FILE: swept_box_collision_resolver.f
hdl/swbc_pkg.sv
hdl/swept_box_collision_resolver.sv
hdl/swbc_checker.sv
verif/tb_top.sv
